### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the hash table unit
// Table geometry, operation and status codes, and the command and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Number of slots. The home slot is taken from the low key bits and the
	// probe wraps by overflow of the index, so this must be a power of two.
	localparam int TABLE_SIZE = 16;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = IDX_W + 1;

	localparam int KEY_W  = 31;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 4;

	// Operation codes.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO_KEY  = 2'd3;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;     // capture the input item and set up the home slot
		logic  read;     // read the slot at the probe index
		logic  advance;  // step the probe index and the probe count
		logic  write;    // store key and payload at the probe index
		logic  emit;     // load the result register
		logic  res_hit;  // result carries the probe index (and data on search)
		stat_t res_status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_key;   // captured key is zero
		logic is_search;  // captured operation is a search
		logic hit_empty;  // probed slot is empty
		logic hit_match;  // probed slot holds the captured key
		logic last_probe; // every slot has now been probed
		logic out_free;   // result register can take a new item this cycle
	} sts_t;

	// Low four bits of a slot index, zero extended when the index is narrower.
	function automatic slot_t to_slot(input idx_t idx);
		logic [IDX_W+SLOT_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

endpackage

### rtl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// Insert and search of nonzero keys in a sixteen-slot table, one result per
// item, with a probe sequencer and a storage datapath.
// ----------------------------------------------------------------------------
// Sequence: the item is captured, then each probed slot is read from memory and
// then compared; a zero key is answered without any probe.
// Items: one at a time, set by the single read port of the slot memories;
// the result register frees the input early.
// Reset: arst_n clears the sequencer, the result valid and all occupied bits,
// so the table is empty at once; payload words are not cleared.
module linear_probe_hash_table_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [lpht_pkg::KEY_W-1:0]   key,
	input  logic [lpht_pkg::DATA_W-1:0]  payload,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lpht_pkg::STAT_W-1:0]  status,
	output logic [lpht_pkg::SLOT_W-1:0]  slot,
	output logic [lpht_pkg::DATA_W-1:0]  read_data
);
	import lpht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Probe sequencer.
	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and result datapath.
	lpht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.key       (key),
		.payload   (payload),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.slot      (slot),
		.read_data (read_data)
	);

endmodule

### rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl: probe sequencer
// Accepts one item at a time, walks the probe sequence one slot per read and
// check pair, and decides the result of each item.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  lpht_pkg::sts_t sts,
	output lpht_pkg::cmd_t cmd
);
	import lpht_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// A new item is taken only while no item is in progress.
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				if (sts.zero_key) begin
					// A zero key is rejected without touching the table.
					if (sts.out_free) begin
						cmd.emit       = 1'b1;
						cmd.res_status = ST_ZERO_KEY;
						state_d        = S_IDLE;
					end
				end else begin
					cmd.read = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.is_search) begin
					// Insert: first empty slot takes the entry.
					if (sts.hit_empty) begin
						if (sts.out_free) begin
							cmd.write      = 1'b1;
							cmd.emit       = 1'b1;
							cmd.res_hit    = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_IDLE;
						end
					end else if (sts.last_probe) begin
						if (sts.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_IDLE;
						end
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end else begin
					// Search: stop at an empty slot, at the first match or after the last slot.
					if (sts.hit_empty || (!sts.hit_match && sts.last_probe)) begin
						if (sts.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = ST_NOT_FOUND;
							state_d        = S_IDLE;
						end
					end else if (sts.hit_match) begin
						if (sts.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_hit    = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_IDLE;
						end
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp: table storage and probe datapath
// Holds the key and payload memories with per-slot occupied bits, the
// captured item, the probe index and count, and the result register.
// ----------------------------------------------------------------------------
module lpht_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpht_pkg::cmd_t        cmd,
	output lpht_pkg::sts_t        sts,
	input  logic                  kind,
	input  logic [lpht_pkg::KEY_W-1:0]  key,
	input  logic [lpht_pkg::DATA_W-1:0] payload,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [lpht_pkg::STAT_W-1:0] status,
	output logic [lpht_pkg::SLOT_W-1:0] slot,
	output logic [lpht_pkg::DATA_W-1:0] read_data
);
	import lpht_pkg::*;

	// Table storage; occupied bits stand in for the all-empty reset of keys.
	key_t                  key_mem [TABLE_SIZE];
	data_t                 pay_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] used_q;

	// Captured item and probe state.
	logic  kind_q;
	key_t  key_q;
	data_t payload_q;
	idx_t  idx_q;
	cnt_t  cnt_q;

	// Registered read of the probed slot.
	logic  rd_used_q;
	key_t  rd_key_q;
	data_t rd_pay_q;

	// Result register.
	logic  out_valid_q;
	stat_t status_q;
	slot_t slot_q;
	data_t read_data_q;

	// Item capture and probe stepping.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			key_q     <= key;
			payload_q <= payload;
			idx_q     <= key[IDX_W-1:0];
			cnt_q     <= '0;
		end else if (cmd.advance) begin
			idx_q <= idx_q + idx_t'(1);
			cnt_q <= cnt_q + cnt_t'(1);
		end
	end

	// Memory write on insert.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			key_mem[idx_q] <= key_q;
			pay_mem[idx_q] <= payload_q;
		end
	end

	// Memory read of the probed slot.
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_key_q <= key_mem[idx_q];
			rd_pay_q <= pay_mem[idx_q];
		end
	end

	// Occupied bits and their registered read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				used_q[idx_q] <= 1'b1;
			end
			if (cmd.read) begin
				rd_used_q <= used_q[idx_q];
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.zero_key   = (key_q == '0);
		sts.is_search  = (kind_q == KIND_SEARCH);
		sts.hit_empty  = !rd_used_q;
		sts.hit_match  = rd_used_q && (rd_key_q == key_q);
		sts.last_probe = (cnt_q == cnt_t'(TABLE_SIZE - 1));
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Result register: holds an item until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= cmd.res_status;
			slot_q      <= cmd.res_hit ? to_slot(idx_q) : '0;
			read_data_q <= (cmd.res_hit && kind_q == KIND_SEARCH) ? rd_pay_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign read_data = read_data_q;

endmodule
